@@ hdl/tlc_pkg.sv @@
// Shared types, constants and helper functions of the traffic light controller.
package tlc_pkg;

    localparam int DIGITS    = 4;
    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int TMR_W     = 16;
    localparam int DUR_W     = 7;
    localparam int BCD_W     = 4;
    localparam int LAMP_W    = 6;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUR_W-1:0] DUR_MAX       = 7'd99;
    localparam logic [DUR_W-1:0] DUR_RED_RST   = 7'd5;
    localparam logic [DUR_W-1:0] DUR_YEL_RST   = 7'd2;
    localparam logic [DUR_W-1:0] DUR_GRN_RST   = 7'd3;

    localparam logic [TMR_W-1:0] TPS_RST   = 16'd100;
    localparam logic [TMR_W-1:0] BLINK_RST = 16'd50;
    localparam logic [TMR_W-1:0] SCAN_RST  = 16'd12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN  = 2'd2;

    // blink masks: red, yellow, green of both ways
    localparam logic [LAMP_W-1:0] MASK_RED = 6'h09;
    localparam logic [LAMP_W-1:0] MASK_YEL = 6'h12;
    localparam logic [LAMP_W-1:0] MASK_GRN = 6'h24;

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_SET_RED    = 2'd1,
        MODE_SET_YELLOW = 2'd2,
        MODE_SET_GREEN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_GREEN  = 2'd1,
        PH_YELLOW = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        BTN_RELEASED = 2'd0,
        BTN_PRESSED  = 2'd1,
        BTN_LONG     = 2'd2
    } btn_t;

    typedef struct packed {
        logic tick;
        logic load;
    } tmr_ctrl_t;

    typedef struct packed {
        logic [BCD_W-1:0] tens;
        logic [BCD_W-1:0] ones;
    } bcd_pair_t;

    // x / 10 as a multiply by the reciprocal; exact for x below 1029
    function automatic bcd_pair_t bcd_split(input logic [DUR_W-1:0] x);
        logic [DUR_W+7:0] prod;
        logic [DUR_W-1:0] q;
        logic [DUR_W-1:0] r;
        bcd_pair_t        res;
        prod     = {8'd0, x} * (DUR_W+8)'(205);
        q        = DUR_W'(prod >> 11);
        r        = x - DUR_W'(q * DUR_W'(10));
        res.tens = q[BCD_W-1:0];
        res.ones = r[BCD_W-1:0];
        return res;
    endfunction

    function automatic logic [2:0] lamp_code(input phase_t p);
        logic [2:0] c;
        unique case (p)
            PH_RED:   c = 3'b001;
            PH_GREEN: c = 3'b100;
            default:  c = 3'b010;
        endcase
        return c;
    endfunction

    function automatic phase_t phase_next(input phase_t p);
        phase_t n;
        unique case (p)
            PH_RED:    n = PH_GREEN;
            PH_GREEN:  n = PH_YELLOW;
            PH_YELLOW: n = PH_RED;
            default:   n = PH_GREEN;
        endcase
        return n;
    endfunction

    function automatic btn_t btn_track(input btn_t s, input logic lv, input logic lg);
        btn_t n;
        n = s;
        unique case (s)
            BTN_RELEASED: if (lv) n = BTN_PRESSED;
            BTN_PRESSED: begin
                if (!lv)     n = BTN_RELEASED;
                else if (lg) n = BTN_LONG;
            end
            default:      if (!lv) n = BTN_RELEASED;
        endcase
        return n;
    endfunction

endpackage

@@ hdl/tlc_timer.sv @@
// Down-counting software timer with a sticky expiry flag.
module tlc_timer #(
    parameter logic [tlc_pkg::TMR_W-1:0] RESET_PERIOD = tlc_pkg::TPS_RST
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tlc_pkg::tmr_ctrl_t        ctrl,
    input  logic [tlc_pkg::TMR_W-1:0] period,
    output logic                      expired
);
    import tlc_pkg::*;

    logic [TMR_W-1:0] cnt_reg;
    logic [TMR_W-1:0] cnt_next;
    logic             exp_reg;
    logic             exp_next;

    // flag as it stands after this tick's countdown
    assign expired = exp_reg | (cnt_reg == TMR_W'(1));

    always_comb begin
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        if (ctrl.tick) begin
            if (ctrl.load) begin
                cnt_next = period;
                exp_next = 1'b0;
            end else begin
                if (cnt_reg != '0) cnt_next = cnt_reg - TMR_W'(1);
                exp_next = expired;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= RESET_PERIOD;
            exp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

endmodule

@@ hdl/two_way_traffic_light_controller_core.sv @@
// Top level of the two-way traffic light controller with settable durations.
//
//  channel  | direction | carries
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | one base tick with three button levels/long flags
//  m_       | out       | lamps, display digit scan and current mode
//  cfg_     | in        | write of ticks_per_second, blink_ticks, scan_ticks
//
// Every accepted tick produces one result in the next cycle; a tick can be taken
// in every cycle while the output is not stalled. The whole update runs through
// one layer of logic between the state registers and the result register; the
// digit split uses a multiply by the reciprocal of ten. A stalled result holds
// in the output register, and s_tready drops only while that register is full
// and not being taken. aresetn is synchronous; cfg_ready is always high.
module two_way_traffic_light_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] mode_level [1] mode_held_long [2] inc_level [3] inc_held_long
    // [4] confirm_level [5] confirm_held_long [7:6] zero
    input  logic [tlc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] lamps [6] digit_strobe [8:7] digit_index [12:9] digit_value
    // [14:13] current_mode [15] zero
    output logic [tlc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlc_pkg::TMR_W-1:0]     cfg_data
);
    import tlc_pkg::*;

    logic accept;

    // configuration
    logic [TMR_W-1:0] tps_reg, blink_reg, scan_per_reg;

    // state
    btn_t             btn_reg  [3];
    btn_t             btn_next [3];
    logic             rs_reg   [2];
    logic             rs_next  [2];
    mode_t            mode_reg, mode_next;
    logic [DUR_W-1:0] dur_reg  [3];
    logic [DUR_W-1:0] dur_next [3];
    logic [DUR_W-1:0] wc_reg   [2];
    logic [DUR_W-1:0] wc_next  [2];
    phase_t           ph_reg   [2];
    phase_t           ph_next  [2];
    logic [LAMP_W-1:0] lamp_reg, lamp_next;
    logic [BCD_W-1:0] buf_reg  [DIGITS];
    logic [BCD_W-1:0] buf_next [DIGITS];
    logic [DIG_IDX_W-1:0] scan_reg, scan_next;

    // output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    // timers: blink, scan, second
    tmr_ctrl_t tc_blink, tc_scan, tc_sec;
    logic      e_blink, e_scan, e_sec;

    logic                 mode_press;
    logic [1:0]           d_sel;
    logic [LAMP_W-1:0]    mask;
    bcd_pair_t            sp_a, sp_b;
    logic                 strobe;
    logic [DIG_IDX_W-1:0] idx;
    logic [BCD_W-1:0]     val;

    assign accept    = s_tvalid & s_tready;
    assign s_tready  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    tlc_timer #(.RESET_PERIOD(BLINK_RST)) u_tmr_blink (
        .aclk(aclk), .aresetn(aresetn), .ctrl(tc_blink), .period(blink_reg),
        .expired(e_blink)
    );
    tlc_timer #(.RESET_PERIOD(SCAN_RST)) u_tmr_scan (
        .aclk(aclk), .aresetn(aresetn), .ctrl(tc_scan), .period(scan_per_reg),
        .expired(e_scan)
    );
    tlc_timer #(.RESET_PERIOD(TPS_RST)) u_tmr_sec (
        .aclk(aclk), .aresetn(aresetn), .ctrl(tc_sec), .period(tps_reg),
        .expired(e_sec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg      <= TPS_RST;
            blink_reg    <= BLINK_RST;
            scan_per_reg <= SCAN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TPS:   tps_reg      <= cfg_data;
                REG_BLINK: blink_reg    <= cfg_data;
                REG_SCAN:  scan_per_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        btn_next[0] = btn_track(btn_reg[0], s_tdata[0], s_tdata[1]);
        btn_next[1] = btn_track(btn_reg[1], s_tdata[2], s_tdata[3]);
        btn_next[2] = btn_track(btn_reg[2], s_tdata[4], s_tdata[5]);
        rs_next     = rs_reg;
        mode_next   = mode_reg;
        dur_next    = dur_reg;
        wc_next     = wc_reg;
        ph_next     = ph_reg;
        lamp_next   = lamp_reg;
        buf_next    = buf_reg;
        scan_next   = scan_reg;
        d_sel       = 2'd0;
        mask        = MASK_RED;
        sp_a        = '0;
        sp_b        = '0;
        tc_blink    = '{tick: accept, load: 1'b0};
        tc_scan     = '{tick: accept, load: 1'b0};
        tc_sec      = '{tick: accept, load: 1'b0};

        mode_press = (btn_next[0] == BTN_PRESSED) && rs_reg[0];
        if (mode_press) begin
            rs_next[0]    = 1'b0;
            tc_blink.load = 1'b1;
            mode_next     = mode_t'(mode_reg + 2'd1);
        end
        if (btn_next[0] == BTN_RELEASED) rs_next[0] = 1'b1;

        if (mode_reg == MODE_NORMAL) begin
            if (e_sec) begin
                tc_sec.load = 1'b1;
                if (wc_next[0] != '0) wc_next[0] = wc_reg[0] - DUR_W'(1);
                if (wc_next[1] != '0) wc_next[1] = wc_reg[1] - DUR_W'(1);
            end
            if (wc_next[1] == '0) begin
                unique case (ph_reg[1])
                    PH_RED:   wc_next[1] = dur_reg[2];
                    PH_GREEN: wc_next[1] = dur_reg[1];
                    default:  wc_next[1] = dur_reg[0];
                endcase
                ph_next[1] = phase_next(ph_reg[1]);
            end
            // way0 lamps show the phase before this tick's advance, way1 lamps the phase after it
            lamp_next = {lamp_code(ph_next[1]), lamp_code(ph_reg[0])};
            if (wc_next[0] == '0) begin
                unique case (ph_reg[0])
                    PH_RED:   wc_next[0] = dur_reg[2];
                    PH_GREEN: wc_next[0] = dur_reg[1];
                    default:  wc_next[0] = dur_reg[0];
                endcase
                ph_next[0] = phase_next(ph_reg[0]);
            end
            sp_a        = bcd_split(wc_next[1]);
            sp_b        = bcd_split(wc_next[0]);
            buf_next[0] = sp_a.tens;
            buf_next[1] = sp_a.ones;
            buf_next[2] = sp_b.tens;
            buf_next[3] = sp_b.ones;
        end else begin
            unique case (mode_reg)
                MODE_SET_RED:    begin d_sel = 2'd0; mask = MASK_RED; end
                MODE_SET_YELLOW: begin d_sel = 2'd1; mask = MASK_YEL; end
                default:         begin d_sel = 2'd2; mask = MASK_GRN; end
            endcase
            sp_a        = bcd_split(dur_reg[d_sel]);
            buf_next[1] = BCD_W'(mode_reg) + BCD_W'(1);
            buf_next[2] = sp_a.tens;
            buf_next[3] = sp_a.ones;
            // a mode press this tick has already reloaded the blink timer
            if (e_blink && !mode_press) begin
                lamp_next     = (lamp_reg ^ mask) & mask;
                tc_blink.load = 1'b1;
            end
            if ((btn_next[1] == BTN_PRESSED) && rs_reg[1]) begin
                rs_next[1] = 1'b0;
                if (dur_reg[d_sel] < DUR_MAX) dur_next[d_sel] = dur_reg[d_sel] + DUR_W'(1);
            end
            if (btn_next[1] == BTN_RELEASED) rs_next[1] = 1'b1;
            // confirm wins over a mode press
            if (btn_next[2] == BTN_PRESSED) mode_next = MODE_NORMAL;
        end

        strobe = 1'b0;
        idx    = '0;
        val    = '0;
        if (e_scan) begin
            tc_scan.load = 1'b1;
            strobe       = 1'b1;
            idx          = scan_reg;
            val          = buf_next[scan_reg];
            scan_next    = scan_reg + DIG_IDX_W'(1);
        end

        m_data_next = {1'b0, mode_next, val, idx, strobe, lamp_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_reg     <= '{BTN_RELEASED, BTN_RELEASED, BTN_RELEASED};
            rs_reg      <= '{1'b0, 1'b0};
            mode_reg    <= MODE_NORMAL;
            dur_reg     <= '{DUR_RED_RST, DUR_YEL_RST, DUR_GRN_RST};
            wc_reg      <= '{DUR_RED_RST, DUR_GRN_RST};
            ph_reg      <= '{PH_RED, PH_GREEN};
            lamp_reg    <= '0;
            buf_reg     <= '{default: '0};
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                btn_reg     <= btn_next;
                rs_reg      <= rs_next;
                mode_reg    <= mode_next;
                dur_reg     <= dur_next;
                wc_reg      <= wc_next;
                ph_reg      <= ph_next;
                lamp_reg    <= lamp_next;
                buf_reg     <= buf_next;
                scan_reg    <= scan_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; holds while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
